// ===== sv/lzss_bitstream_decoder_core_defines.svh =====
// Assertion macros shared by the LZSS decoder RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef LZSS_BITSTREAM_DECODER_CORE_DEFINES_SVH
`define LZSS_BITSTREAM_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LZBD_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("lzbd assertion failed");
`define LZBD_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("lzbd assertion failed");
`else
`define LZBD_ASSERT_IMP(lbl, a, c)
`define LZBD_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ===== sv/lzbd_pkg.sv =====
// Types and constants of the LZSS decoder.
// No dependencies.
package lzbd_pkg;

  localparam int WIN_AW      = 12;
  localparam int WIN_DEPTH   = 4096;
  localparam int RES_MAX     = 31;
  localparam logic [3:0] START_WIDTH = 4'd8;
  localparam logic [3:0] WIDTH_LIMIT = 4'd13;
  localparam logic [3:0] LEN_BITS    = 4'd5;

  localparam logic [2:0] KIND_BYTE     = 3'd0;
  localparam logic [2:0] KIND_COMPLETE = 3'd1;
  localparam logic [2:0] KIND_TRUNC    = 3'd2;
  localparam logic [2:0] KIND_WIDTH    = 3'd3;
  localparam logic [2:0] KIND_CAPACITY = 3'd4;
  localparam logic [2:0] KIND_SIZE     = 3'd5;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_EXACT    = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  kind;
    logic [23:0] produced_count;
    logic [23:0] consumed_count;
    logic        last_result;
  } result_t;

endpackage

// ===== sv/lzbd_fifo.sv =====
// Small register queue used on both sides of the decoder.
// No dependencies.
module lzbd_fifo #(
  parameter int DEPTH = 2,
  parameter int W     = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== sv/lzbd_engine.sv =====
// Back end of the decoder: bit-serial token parser, window and copy loop.
// Depends on lzbd_pkg and the assertion macro header.
`include "lzss_bitstream_decoder_core_defines.svh"
module lzbd_engine
  import lzbd_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_empty_i,
  input  item_t       in_item_i,
  output logic        in_pop_o,
  input  logic        out_full_i,
  output logic        out_push_o,
  output result_t     out_res_o,
  input  logic [23:0] capacity_i,
  input  logic        exact_i
);
  localparam int CW = (COUNT_BITS > 24) ? COUNT_BITS : 24;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BIT   = 3'd1;
  localparam logic [2:0] S_CPRD  = 3'd2;
  localparam logic [2:0] S_CPWR  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  localparam logic [2:0] PH_TAG = 3'd0;
  localparam logic [2:0] PH_LIT = 3'd1;
  localparam logic [2:0] PH_OFF = 3'd2;
  localparam logic [2:0] PH_ESC = 3'd3;
  localparam logic [2:0] PH_LEN = 3'd4;

  logic [7:0] win_q [WIN_DEPTH];
  logic [7:0] rd_q;
  logic       rdv_q;

  logic [2:0]  st_q, st_d, phase_q, phase_d, bit_q, bit_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d, fin_q, fin_d, wfull_q, wfull_d;
  logic [WIN_AW-1:0] wp_q, wp_d, cpos_q, cpos_d;
  logic [3:0]  width_q, width_d, left_q, left_d;
  logic [12:0] acc_q, acc_d;
  logic [4:0]  cnt_q, cnt_d, n_q, n_d;
  logic [COUNT_BITS-1:0] prod_q, prod_d, cons_q, cons_d;
  result_t     pend_q, pend_d;
  logic        pend_v_q, pend_v_d;

  logic        emit_c, emit_st_c, push_c, stall_c, we_c;
  logic [2:0]  emit_kind_c;
  logic [7:0]  emit_byte_c, wdata_c, cp_byte;
  logic        bit_c, go_copy;
  logic [12:0] acc_n;
  result_t     res_c;

  // Byte emission: either writes the window or ends the stream on capacity.
  function automatic logic cap_hit(logic [COUNT_BITS-1:0] p, logic [23:0] c);
    return CW'(p) >= CW'(c);
  endfunction

  always_comb begin
    st_d = st_q; phase_d = phase_q; bit_d = bit_q; byte_d = byte_q;
    last_d = last_q; fin_d = fin_q; wfull_d = wfull_q; wp_d = wp_q;
    cpos_d = cpos_q; width_d = width_q; left_d = left_q; acc_d = acc_q;
    cnt_d = cnt_q; n_d = n_q; prod_d = prod_q; cons_d = cons_q;
    pend_d = pend_q; pend_v_d = pend_v_q;
    emit_c = 1'b0; emit_st_c = 1'b0; emit_kind_c = KIND_BYTE; emit_byte_c = '0;
    we_c = 1'b0; wdata_c = '0; push_c = 1'b0; in_pop_o = 1'b0;
    bit_c = byte_q[bit_q];
    acc_n = {acc_q[11:0], bit_c};
    go_copy = 1'b0;
    cp_byte = rdv_q ? rd_q : 8'h00;

    case (st_q)
      S_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          if (in_item_i.first_byte) begin
            wp_d = '0; wfull_d = 1'b0; width_d = START_WIDTH; phase_d = PH_TAG;
            acc_d = '0; left_d = '0; cpos_d = '0; prod_d = '0; cons_d = '0;
            fin_d = 1'b0;
          end
          if (!(fin_q && !in_item_i.first_byte)) begin
            if (cons_d != '1) cons_d = cons_d + 1'b1;
            byte_d = in_item_i.in_byte;
            last_d = in_item_i.last_byte;
            bit_d  = 3'd7;
            n_d    = '0;
            st_d   = S_BIT;
          end
        end
      end
      S_BIT: begin
        case (phase_q)
          PH_TAG: begin
            phase_d = bit_c ? PH_OFF : PH_LIT;
            left_d  = bit_c ? width_q : 4'd8;
            acc_d   = '0;
          end
          PH_ESC: begin
            if (!bit_c) begin
              emit_c = 1'b1; emit_st_c = 1'b1; fin_d = 1'b1;
              emit_kind_c = KIND_COMPLETE;
              if (exact_i) begin
                if (CW'(prod_q) != CW'(capacity_i)) emit_kind_c = KIND_SIZE;
              end else if (capacity_i == '0) begin
                emit_kind_c = KIND_CAPACITY;
              end
            end else begin
              width_d = width_q + 1'b1;
              phase_d = PH_TAG;
              if (width_d >= WIDTH_LIMIT) begin
                emit_c = 1'b1; emit_st_c = 1'b1; fin_d = 1'b1;
                emit_kind_c = KIND_WIDTH;
              end
            end
          end
          PH_LIT, PH_OFF, PH_LEN: begin
            acc_d = acc_n;
            if (left_q != '0) left_d = left_q - 1'b1;
            if (left_d == '0) begin
              case (phase_q)
                PH_LIT: begin
                  phase_d = PH_TAG;
                  emit_c  = 1'b1;
                  if (cap_hit(prod_q, capacity_i)) begin
                    emit_st_c = 1'b1; emit_kind_c = KIND_CAPACITY; fin_d = 1'b1;
                  end else begin
                    if (prod_q != '1) prod_d = prod_q + 1'b1;
                    we_c = 1'b1; wdata_c = acc_n[7:0];
                    wp_d = wp_q + 1'b1;
                    if (wp_q == '1) wfull_d = 1'b1;
                    emit_byte_c = acc_n[7:0];
                  end
                end
                PH_OFF: begin
                  if (acc_n == '0) begin
                    phase_d = PH_ESC;
                  end else begin
                    cpos_d  = WIN_AW'(acc_n - 13'd1);
                    phase_d = PH_LEN;
                    left_d  = LEN_BITS;
                    acc_d   = '0;
                  end
                end
                default: begin
                  phase_d = PH_TAG;
                  cnt_d   = acc_n[4:0];
                  go_copy = (acc_n[4:0] != '0);
                end
              endcase
            end
          end
          default: phase_d = PH_TAG;
        endcase
        if (fin_d) st_d = S_END;
        else if (go_copy) st_d = S_CPRD;
        else if (bit_q == '0) st_d = S_END;
        else bit_d = bit_q - 1'b1;
      end
      S_CPRD: st_d = S_CPWR;
      S_CPWR: begin
        emit_c = 1'b1;
        if (cap_hit(prod_q, capacity_i)) begin
          emit_st_c = 1'b1; emit_kind_c = KIND_CAPACITY; fin_d = 1'b1;
        end else begin
          if (prod_q != '1) prod_d = prod_q + 1'b1;
          we_c = 1'b1; wdata_c = cp_byte;
          wp_d = wp_q + 1'b1;
          if (wp_q == '1) wfull_d = 1'b1;
          emit_byte_c = cp_byte;
        end
        cpos_d = cpos_q + 1'b1;
        cnt_d  = cnt_q - 1'b1;
        if (fin_d) st_d = S_END;
        else if (cnt_d != '0) st_d = S_CPRD;
        else if (bit_q == '0) st_d = S_END;
        else begin
          bit_d = bit_q - 1'b1;
          st_d  = S_BIT;
        end
      end
      S_END: begin
        if (!fin_q && last_q) begin
          emit_c = 1'b1; emit_st_c = 1'b1; emit_kind_c = KIND_TRUNC; fin_d = 1'b1;
        end
        st_d = S_FLUSH;
      end
      S_FLUSH: begin
        push_c   = pend_v_q;
        pend_v_d = 1'b0;
        st_d     = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase

    res_c.out_byte       = emit_byte_c;
    res_c.kind           = emit_kind_c;
    res_c.produced_count = 24'(prod_d);
    res_c.consumed_count = 24'(cons_q);
    res_c.last_result    = 1'b0;

    // The step's last result waits in pend_q so that it can be flagged or
    // displaced by a status once the per-step limit is reached.
    if (emit_c) begin
      if (n_q == 5'(RES_MAX)) begin
        if (emit_st_c) pend_d = res_c;
      end else begin
        push_c   = pend_v_q;
        pend_d   = res_c;
        pend_v_d = 1'b1;
        n_d      = n_q + 1'b1;
      end
    end
    stall_c = push_c && out_full_i;
  end

  assign out_push_o = push_c && !out_full_i;
  always_comb begin
    out_res_o = pend_q;
    out_res_o.last_result = (st_q == S_FLUSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; phase_q <= PH_TAG; bit_q <= '0; last_q <= 1'b0;
      fin_q <= 1'b0; wfull_q <= 1'b0; wp_q <= '0; cpos_q <= '0;
      width_q <= START_WIDTH; left_q <= '0; acc_q <= '0; cnt_q <= '0;
      n_q <= '0; prod_q <= '0; cons_q <= '0; pend_v_q <= 1'b0;
    end else if (!stall_c) begin
      st_q <= st_d; phase_q <= phase_d; bit_q <= bit_d; last_q <= last_d;
      fin_q <= fin_d; wfull_q <= wfull_d; wp_q <= wp_d; cpos_q <= cpos_d;
      width_q <= width_d; left_q <= left_d; acc_q <= acc_d; cnt_q <= cnt_d;
      n_q <= n_d; prod_q <= prod_d; cons_q <= cons_d; pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_c) begin
      byte_q <= byte_d;
      pend_q <= pend_d;
    end
  end

  // Window: one write port, one registered read; unwritten entries read as zero.
  always_ff @(posedge clk_i) begin
    if (we_c && !stall_c) win_q[wp_q] <= wdata_c;
    if (st_q == S_CPRD) begin
      rd_q  <= win_q[cpos_q];
      rdv_q <= wfull_q || (cpos_q < wp_q);
    end
  end

  `LZBD_ASSERT_IMP(a_copy_cnt, st_q == S_CPWR, cnt_q != '0)
  `LZBD_ASSERT_IMP(a_width_ok, !fin_q, width_q < WIDTH_LIMIT)
  `LZBD_ASSERT_IMP(a_push_room, out_push_o, !out_full_i)
  `LZBD_ASSERT_NXT(a_idle_clean, st_q == S_FLUSH && !out_full_i, !pend_v_q)

endmodule

// ===== sv/lzss_bitstream_decoder_core.sv =====
// Top level of the LZSS decoder: input queue, decode engine, result queue.
// Depends on lzbd_pkg, lzbd_fifo, lzbd_engine.
//
// Usage:
//   Input channel: drive in_byte_i, first_byte_i, last_byte_i with push; a
//   beat moves when push is high and full is low. A two-entry queue holds
//   beats while the engine is busy.
//   Result channel: while empty is low the oldest result sits on the result
//   ports; a beat moves when pop is high and empty is low.
//   Configuration: cfg_we_i writes cfg_wdata_i into the register chosen by
//   cfg_idx_i (0 output capacity, 1 exact size mode); write only when idle.
// Processing per byte:
//   The engine takes each byte in its idle state, then parses one bit per
//   cycle (8 bits) while the result queue has room, then a window read and
//   a write for each copied byte, then its end and flush states close the
//   step; it takes no new byte before that. The window has one write port
//   and one registered read. A result passes through the engine's pending
//   register pend_q and the result queue before it reaches the ports.
// Reset: clears both queues and starts a fresh stream with width 8; the
//   window needs no clearing pass, unwritten entries read as zero.
// Stall: when the result queue fills, the engine holds its state until a
//   pop frees room; the input queue then fills and raises full.
module lzss_bitstream_decoder_core
  import lzbd_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  kind_o,
  output logic [23:0] produced_count_o,
  output logic [23:0] consumed_count_o,
  output logic        last_result_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  item_t   in_item, eng_item;
  result_t eng_res, out_res;
  logic    in_empty, eng_pop, out_full, eng_push;
  logic [23:0] capacity_q;
  logic        exact_q;

  // Configuration registers: capacity resets to 64 KiB, count-only mode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 24'd65536;
      exact_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPACITY: capacity_q <= cfg_wdata_i;
        CFG_EXACT:    exact_q    <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  assign in_item.in_byte    = in_byte_i;
  assign in_item.first_byte = first_byte_i;
  assign in_item.last_byte  = last_byte_i;

  // Front: hold accepted beats until the engine takes them.
  lzbd_fifo #(.DEPTH(2), .W($bits(item_t))) u_in_q (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(in_item), .full_o(full),
    .pop_i(eng_pop), .data_o(eng_item), .empty_o(in_empty)
  );

  // Back: parse bits, run copies, form results.
  lzbd_engine #(.COUNT_BITS(COUNT_BITS)) u_engine (
    .clk_i, .rst_ni,
    .in_empty_i(in_empty), .in_item_i(eng_item), .in_pop_o(eng_pop),
    .out_full_i(out_full), .out_push_o(eng_push), .out_res_o(eng_res),
    .capacity_i(capacity_q), .exact_i(exact_q)
  );

  // Results wait here until the receiver pops them.
  lzbd_fifo #(.DEPTH(4), .W($bits(result_t))) u_out_q (
    .clk_i, .rst_ni,
    .push_i(eng_push), .data_i(eng_res), .full_o(out_full),
    .pop_i(pop), .data_o(out_res), .empty_o(empty)
  );

  assign out_byte_o       = out_res.out_byte;
  assign kind_o           = out_res.kind;
  assign produced_count_o = out_res.produced_count;
  assign consumed_count_o = out_res.consumed_count;
  assign last_result_o    = out_res.last_result;

endmodule
